### src/art_pkg.sv
// ---------------------------------------------------------------------------
// Address region table package
// Shared widths, codes, the table entry record and the scan status flags.
// ---------------------------------------------------------------------------
package art_pkg;

   localparam int VADDR_W    = 47;
   localparam int LEN_W      = 48;
   localparam int PERM_W     = 8;
   localparam int BTYPE_W    = 3;
   localparam int END_W      = LEN_W + 1;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 112;

   localparam logic [LEN_W-1:0]  CURSOR_RESET = 48'h7000_0000_0000;
   localparam logic [PERM_W-1:0] PERM_DEVICE  = 8'h08;
   localparam logic [PERM_W-1:0] PERM_NOCACHE = 8'h10;

   localparam logic [BTYPE_W-1:0] BT_DATA      = 3'd0;
   localparam logic [BTYPE_W-1:0] BT_NOCACHE   = 3'd1;
   localparam logic [BTYPE_W-1:0] BT_ANON      = 3'd2;
   localparam logic [BTYPE_W-1:0] BT_DEVICE    = 3'd3;
   localparam logic [BTYPE_W-1:0] BT_SHARED    = 3'd4;
   localparam logic [BTYPE_W-1:0] BT_FORBIDDEN = 3'd5;

   typedef enum logic [1:0] {
      OP_MAP    = 2'd0,
      OP_MMAP   = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_UNMAP  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_OVERLAP   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_BAD       = 3'd4
   } status_type;

   typedef struct packed {
      logic [VADDR_W-1:0] start;
      logic [LEN_W-1:0]   size;
      logic [PERM_W-1:0]  perm;
      logic [BTYPE_W-1:0] btype;
   } entry_type;

   typedef struct packed {
      logic free_found;
      logic ovl_found;
      logic hit_found;
   } scan_flags_type;

   function automatic logic eager_of(input logic [BTYPE_W-1:0] t);
      return (t == BT_DATA) || (t == BT_NOCACHE) || (t == BT_DEVICE);
   endfunction

endpackage

### src/art_entry_mem.sv
// ---------------------------------------------------------------------------
// Address region table entry memory
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module art_entry_mem #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  art_pkg::entry_type  wr_data,
   input  logic [IDX_W-1:0]    rd_addr,
   output art_pkg::entry_type  rd_data
);

   art_pkg::entry_type mem_ff [DEPTH];
   art_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/art_scan.sv
// ---------------------------------------------------------------------------
// Address region table scanner
// Checks one entry per cycle while step is high for overlap, containment and a free slot, and
// keeps the first free slot and the first containing region.
// ---------------------------------------------------------------------------
module art_scan #(
   parameter int IDX_W = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clear,
   input  logic                                step,
   input  logic [IDX_W-1:0]                    idx,
   input  art_pkg::entry_type                  entry,
   input  logic                                entry_valid,
   input  logic [art_pkg::VADDR_W-1:0]         va,
   input  logic [art_pkg::LEN_W-1:0]           cand_start,
   input  logic [art_pkg::LEN_W-1:0]           new_size,
   input  logic [art_pkg::END_W-1:0]           new_end,
   output art_pkg::scan_flags_type             flags,
   output logic [IDX_W-1:0]                    free_idx,
   output logic [IDX_W-1:0]                    hit_idx,
   output art_pkg::entry_type                  hit_entry
);

   art_pkg::scan_flags_type flags_ff, flags_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]        hit_idx_ff, hit_idx_in;
   art_pkg::entry_type      hit_ff, hit_in;

   logic [art_pkg::END_W-1:0] e_end;
   logic                      is_ovl;
   logic                      is_hit;

   assign e_end  = {1'b0, entry.start} + {1'b0, entry.size};
   assign is_ovl = entry_valid && (entry.size != '0) && (new_size != '0) &&
                   ({1'b0, cand_start} < e_end) && ({2'b00, entry.start} < new_end);
   assign is_hit = entry_valid && (va >= entry.start) && ({2'b00, va} < e_end);

   always_comb begin
      flags_in    = flags_ff;
      free_idx_in = free_idx_ff;
      hit_idx_in  = hit_idx_ff;
      hit_in      = hit_ff;
      if (clear) begin
         flags_in = '0;
      end else if (step) begin
         if (!entry_valid && !flags_ff.free_found) begin
            flags_in.free_found = 1'b1;
            free_idx_in         = idx;
         end
         if (is_ovl) begin
            flags_in.ovl_found = 1'b1;
         end
         if (is_hit && !flags_ff.hit_found) begin
            flags_in.hit_found = 1'b1;
            hit_idx_in         = idx;
            hit_in             = entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
      free_idx_ff <= free_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_ff      <= hit_in;
   end

   assign flags     = flags_ff;
   assign free_idx  = free_idx_ff;
   assign hit_idx   = hit_idx_ff;
   assign hit_entry = hit_ff;

endmodule

### src/address_region_table_top.sv
// ---------------------------------------------------------------------------
// Address region table
// Keeps a table of address regions and runs map, mmap, lookup and unmap
// commands against it, one command at a time.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transfer: req_tuser is the opcode, req_tdata
//   the address, length, requested permission and backing type.
//   rsp_* returns exactly one result per command: rsp_tuser is the status,
//   rsp_tdata the region fields and the eager-mapping flag (all zero when the
//   status is not ok).
//   Each command first takes the request and issues the first read, then
//   the scanner checks one table entry per cycle as it walks the entry
//   memory through its single read port, and last the result is written
//   back and loaded into the result register.
//   req_tready is high only while no command is in progress; the result
//   register lets a new command start while a result is still waiting.
//   If rsp_tready stays low, the next command finishes its scan and holds
//   until the waiting result is taken.
//   Reset empties the table (all valid bits clear) and sets the mmap cursor
//   to 0x7000_0000_0000; the entry memory itself is not cleared.
// ---------------------------------------------------------------------------
module address_region_table_top #(
   parameter int TABLE_ENTRIES = 16,
   parameter int PAGE_BYTES    = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [46:0] vaddr, [94:47] length, [102:95] perm_in, [105:103] backing_type
   input  logic [art_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] opcode
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [46:0] region_start, [94:47] region_size, [102:95] region_perm,
   // [105:103] region_type, [106] eager_map
   output logic [art_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [2:0] status
   output logic [2:0]                         rsp_tuser
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [63:0] ADDR_LIMIT = 64'(1) << art_pkg::VADDR_W;
   localparam logic [art_pkg::VADDR_W-1:0] PAGE_MASK =
      ~art_pkg::VADDR_W'(PAGE_BYTES - 1);
   localparam logic [art_pkg::LEN_W-1:0] PAGE_LEN   = art_pkg::LEN_W'(PAGE_BYTES);
   localparam logic [art_pkg::LEN_W-1:0] PAGE_LOW   = art_pkg::LEN_W'(PAGE_BYTES - 1);
   localparam logic [IDX_W-1:0]          LAST_IDX   = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   // request unpack
   art_pkg::opcode_type                in_op;
   logic [art_pkg::VADDR_W-1:0]        in_va;
   logic [art_pkg::LEN_W-1:0]          in_len;
   logic [art_pkg::PERM_W-1:0]         in_perm;
   logic [art_pkg::BTYPE_W-1:0]        in_typ;

   assign in_op   = art_pkg::opcode_type'(req_tuser);
   assign in_va   = req_tdata[46:0];
   assign in_len  = req_tdata[94:47];
   assign in_perm = req_tdata[102:95];
   assign in_typ  = req_tdata[105:103];

   // registers
   state_type                          state_ff, state_in;
   logic [IDX_W-1:0]                   cnt_ff, cnt_in;
   art_pkg::opcode_type                op_ff, op_in;
   logic [art_pkg::VADDR_W-1:0]        va_ff, va_in;
   logic [art_pkg::LEN_W-1:0]          len_ff, len_in;
   logic [art_pkg::LEN_W-1:0]          s_ff, s_in;
   logic [art_pkg::LEN_W-1:0]          z_ff, z_in;
   logic [art_pkg::END_W-1:0]          end_ff, end_in;
   logic [art_pkg::PERM_W-1:0]         perm_ff, perm_in;
   logic [art_pkg::BTYPE_W-1:0]        typ_ff, typ_in;
   logic                               bad_ff, bad_in;
   logic [art_pkg::LEN_W-1:0]          cursor_ff, cursor_in;
   logic [TABLE_ENTRIES-1:0]           valid_ff, valid_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [2:0]                         rsp_status_ff, rsp_status_in;
   art_pkg::entry_type                 rsp_entry_ff, rsp_entry_in;
   logic                               rsp_eager_ff, rsp_eager_in;

   // setup datapath
   logic [art_pkg::VADDR_W-1:0]        map_s;
   logic [art_pkg::LEN_W-1:0]          map_z;
   logic [art_pkg::LEN_W-1:0]          new_s;
   logic [art_pkg::LEN_W-1:0]          new_z;
   logic [art_pkg::END_W-1:0]          new_end;
   logic                               over_lim;
   logic                               len_aligned;
   logic                               req_bad;
   logic [art_pkg::PERM_W-1:0]         req_perm;

   // scanner and memory
   logic                               accept;
   logic                               out_free;
   logic [IDX_W-1:0]                   rd_addr;
   art_pkg::entry_type                 rd_entry;
   art_pkg::scan_flags_type            flags;
   logic [IDX_W-1:0]                   free_idx;
   logic [IDX_W-1:0]                   hit_idx;
   art_pkg::entry_type                 hit_entry;
   logic                               wr_en;
   art_pkg::entry_type                 new_entry;
   art_pkg::status_type                status;
   logic                               do_clear;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign map_s       = in_va & PAGE_MASK;
   assign map_z       = (in_len < PAGE_LEN) ? PAGE_LEN : in_len;
   assign new_s       = (in_op == art_pkg::OP_MMAP) ? cursor_ff : {1'b0, map_s};
   assign new_z       = (in_op == art_pkg::OP_MMAP) ? in_len : map_z;
   assign new_end     = {1'b0, new_s} + {1'b0, new_z};
   assign over_lim    = 64'(new_end) > ADDR_LIMIT;
   assign len_aligned = (in_len & PAGE_LOW) == '0;

   always_comb begin
      req_bad  = 1'b0;
      req_perm = in_perm;
      case (in_op)
         art_pkg::OP_MAP: begin
            req_bad = (in_typ > art_pkg::BT_FORBIDDEN) || over_lim;
            if (in_typ == art_pkg::BT_DEVICE) begin
               req_perm = in_perm | art_pkg::PERM_DEVICE;
            end else if (in_typ == art_pkg::BT_NOCACHE) begin
               req_perm = in_perm | art_pkg::PERM_NOCACHE;
            end
         end
         art_pkg::OP_MMAP: begin
            req_bad = !((in_typ == art_pkg::BT_ANON) || (in_typ == art_pkg::BT_SHARED)) ||
                      !len_aligned || over_lim;
         end
         default: begin
            req_bad = 1'b0;
         end
      endcase
   end

   assign rd_addr = (state_ff == S_SCAN) ? (cnt_ff + IDX_W'(1)) : '0;

   art_entry_mem #(
      .DEPTH (TABLE_ENTRIES),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_idx),
      .wr_data (new_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   art_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .clear       (accept),
      .step        (state_ff == S_SCAN),
      .idx         (cnt_ff),
      .entry       (rd_entry),
      .entry_valid (valid_ff[cnt_ff]),
      .va          (va_ff),
      .cand_start  (s_ff),
      .new_size    (z_ff),
      .new_end     (end_ff),
      .flags       (flags),
      .free_idx    (free_idx),
      .hit_idx     (hit_idx),
      .hit_entry   (hit_entry)
   );

   assign new_entry.start = s_ff[art_pkg::VADDR_W-1:0];
   assign new_entry.size  = z_ff;
   assign new_entry.perm  = perm_ff;
   assign new_entry.btype = typ_ff;

   // decide the command outcome from the scan
   logic ins;
   always_comb begin
      status   = art_pkg::ST_OK;
      ins      = 1'b0;
      do_clear = 1'b0;
      case (op_ff)
         art_pkg::OP_MAP, art_pkg::OP_MMAP: begin
            if (bad_ff) begin
               status = art_pkg::ST_BAD;
            end else if (!flags.free_found) begin
               status = art_pkg::ST_FULL;
            end else if (flags.ovl_found) begin
               status = art_pkg::ST_OVERLAP;
            end else begin
               ins = 1'b1;
            end
         end
         art_pkg::OP_LOOKUP: begin
            if (!flags.hit_found) begin
               status = art_pkg::ST_NOT_FOUND;
            end
         end
         art_pkg::OP_UNMAP: begin
            if (!flags.hit_found) begin
               status = art_pkg::ST_NOT_FOUND;
            end else if ((len_ff != '0) &&
                         ((va_ff != hit_entry.start) || (len_ff != hit_entry.size))) begin
               status = art_pkg::ST_BAD;
            end else begin
               do_clear = 1'b1;
            end
         end
         default: begin
            status = art_pkg::ST_BAD;
         end
      endcase
   end

   assign wr_en = (state_ff == S_DONE) && out_free && ins;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      va_in         = va_ff;
      len_in        = len_ff;
      s_in          = s_ff;
      z_in          = z_ff;
      end_in        = end_ff;
      perm_in       = perm_ff;
      typ_in        = typ_ff;
      bad_in        = bad_ff;
      cursor_in     = cursor_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_eager_in  = rsp_eager_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
               cnt_in   = '0;
               op_in    = in_op;
               va_in    = in_va;
               len_in   = in_len;
               s_in     = new_s;
               z_in     = new_z;
               end_in   = new_end;
               perm_in  = req_perm;
               typ_in   = in_typ;
               bad_in   = req_bad;
            end
         end
         S_SCAN: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = status;
               rsp_entry_in  = '0;
               rsp_eager_in  = 1'b0;
               if (status == art_pkg::ST_OK) begin
                  rsp_entry_in = ins ? new_entry : hit_entry;
                  rsp_eager_in = art_pkg::eager_of(ins ? typ_ff : hit_entry.btype);
               end
               // advance the cursor once the bad-request and full checks pass
               if ((op_ff == art_pkg::OP_MMAP) && !bad_ff && flags.free_found) begin
                  cursor_in = end_ff[art_pkg::LEN_W-1:0];
               end
               if (ins) begin
                  valid_in[free_idx] = 1'b1;
               end
               if (do_clear) begin
                  valid_in[hit_idx] = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         cursor_ff    <= art_pkg::CURSOR_RESET;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cursor_ff    <= cursor_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      va_ff         <= va_in;
      len_ff        <= len_in;
      s_ff          <= s_in;
      z_ff          <= z_in;
      end_ff        <= end_in;
      perm_ff       <= perm_in;
      typ_ff        <= typ_in;
      bad_ff        <= bad_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_eager_ff  <= rsp_eager_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {5'b00000, rsp_eager_ff, rsp_entry_ff.btype, rsp_entry_ff.perm,
                        rsp_entry_ff.size, rsp_entry_ff.start};

endmodule

### verif/region_table_check_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Address region table scoreboard
// Mirrors the region table and the mmap bump cursor for every accepted
// command, queues the result each command should give, and compares the
// returned results field by field in order.
// ---------------------------------------------------------------------------
package region_table_check_pkg;

   import art_pkg::*;

   localparam int          SLOTS      = 16;
   localparam int          PAGE_SHIFT = 12;
   localparam logic [63:0] PAGE       = 64'd4096;
   localparam logic [63:0] SPACE_END  = 64'h8000_0000_0000;

   typedef struct packed {
      status_type         status;
      logic [VADDR_W-1:0] start;
      logic [LEN_W-1:0]   span;
      logic [PERM_W-1:0]  perm;
      logic [BTYPE_W-1:0] btype;
      logic               eager;
   } region_result_type;

   class region_table_scoreboard;
      bit                 slot_valid [SLOTS];
      logic [VADDR_W-1:0] slot_start [SLOTS];
      logic [LEN_W-1:0]   slot_span  [SLOTS];
      logic [PERM_W-1:0]  slot_perm  [SLOTS];
      logic [BTYPE_W-1:0] slot_btype [SLOTS];
      logic [LEN_W-1:0]   bump_cursor;
      region_result_type  awaited_results [$];
      int                 error_count;
      int                 op_count [4];
      int                 status_count [5];

      function new();
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         foreach (op_count[i]) op_count[i] = 0;
         foreach (status_count[i]) status_count[i] = 0;
         bump_cursor = CURSOR_RESET;
         error_count = 0;
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      function int free_slot();
         for (int i = 0; i < SLOTS; i++)
            if (!slot_valid[i]) return i;
         return -1;
      endfunction

      // half-open intervals; empty regions never collide
      function bit collides(logic [63:0] s, logic [63:0] z);
         if (z == 0) return 1'b0;
         for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_span[i] != 0 &&
                s < 64'(slot_start[i]) + 64'(slot_span[i]) &&
                64'(slot_start[i]) < s + z)
               return 1'b1;
         return 1'b0;
      endfunction

      function region_result_type describe(int i);
         region_result_type r;
         r        = '0;
         r.status = ST_OK;
         r.start  = slot_start[i];
         r.span   = slot_span[i];
         r.perm   = slot_perm[i];
         r.btype  = slot_btype[i];
         r.eager  = (slot_btype[i] == BT_DATA) || (slot_btype[i] == BT_NOCACHE) ||
                    (slot_btype[i] == BT_DEVICE);
         return r;
      endfunction

      function region_result_type store(logic [63:0] s, logic [63:0] z,
                                        logic [PERM_W-1:0] p, logic [BTYPE_W-1:0] t);
         int i;
         i = free_slot();
         slot_valid[i] = 1'b1;
         slot_start[i] = s[VADDR_W-1:0];
         slot_span[i]  = z[LEN_W-1:0];
         slot_perm[i]  = p;
         slot_btype[i] = t;
         return describe(i);
      endfunction

      function void note_command(opcode_type op, logic [VADDR_W-1:0] va,
                                 logic [LEN_W-1:0] len, logic [PERM_W-1:0] perm,
                                 logic [BTYPE_W-1:0] btype);
         region_result_type r;
         logic [63:0]       s;
         logic [63:0]       z;
         logic [63:0]       e;
         logic [PERM_W-1:0] p;
         int                hit;
         r        = '0;
         r.status = ST_OK;
         hit      = -1;
         op_count[op]++;
         case (op)
            OP_MAP: begin
               s = 64'({va[VADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}});
               z = (64'(len) < PAGE) ? PAGE : 64'(len);
               p = perm;
               if (btype == BT_DEVICE) p = p | PERM_DEVICE;
               else if (btype == BT_NOCACHE) p = p | PERM_NOCACHE;
               if (btype > BT_FORBIDDEN || s + z > SPACE_END) r.status = ST_BAD;
               else if (free_slot() < 0) r.status = ST_FULL;
               else if (collides(s, z)) r.status = ST_OVERLAP;
               else r = store(s, z, p, btype);
            end
            OP_MMAP: begin
               s = 64'(bump_cursor);
               z = 64'(len);
               if ((btype != BT_ANON && btype != BT_SHARED) ||
                   len[PAGE_SHIFT-1:0] != 0 || s + z > SPACE_END) begin
                  r.status = ST_BAD;
               end else if (free_slot() < 0) begin
                  r.status = ST_FULL;
               end else begin
                  // advance even when the region is then refused for overlap
                  e           = s + z;
                  bump_cursor = e[LEN_W-1:0];
                  if (collides(s, z)) r.status = ST_OVERLAP;
                  else r = store(s, z, perm, btype);
               end
            end
            default: begin
               for (int i = 0; i < SLOTS; i++)
                  if (hit < 0 && slot_valid[i] && va >= slot_start[i] &&
                      64'(va) < 64'(slot_start[i]) + 64'(slot_span[i]))
                     hit = i;
               if (hit < 0) begin
                  r.status = ST_NOT_FOUND;
               end else if (op == OP_UNMAP && len != 0 &&
                            (va != slot_start[hit] || len != slot_span[hit])) begin
                  r.status = ST_BAD;
               end else begin
                  r = describe(hit);
                  if (op == OP_UNMAP) slot_valid[hit] = 1'b0;
               end
            end
         endcase
         awaited_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
         end
      endfunction

      function void check_result(logic [2:0] status, logic [RSP_DATA_W-1:0] data);
         region_result_type e;
         if (awaited_results.size() == 0) begin
            $error("result transfer with no command pending: status %0d", status);
            error_count++;
            return;
         end
         e = awaited_results.pop_front();
         status_count[e.status]++;
         compare_field("status",       64'(e.status), 64'(status));
         compare_field("region_start", 64'(e.start),  64'(data[46:0]));
         compare_field("region_size",  64'(e.span),   64'(data[94:47]));
         compare_field("region_perm",  64'(e.perm),   64'(data[102:95]));
         compare_field("region_type",  64'(e.btype),  64'(data[105:103]));
         compare_field("eager_map",    64'(e.eager),  64'(data[106]));
         compare_field("rsp_tdata padding", 64'h0,    64'(data[111:107]));
      endfunction
   endclass

endpackage

### verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Address region table testbench
// Drives map, mmap, lookup and unmap commands (a directed opening, a long
// random run biased toward real regions, then a cursor exhaustion tail) with
// random gaps and result stalls, and checks every result on the scoreboard.
// ---------------------------------------------------------------------------
module testbench;

   import art_pkg::*;
   import region_table_check_pkg::*;

   localparam int RANDOM_ITEMS = 400;
   localparam int QUIET_FROM   = 340;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;

   bit                     req_gaps;
   bit                     rsp_stalls;
   region_table_scoreboard sb;

   address_region_table_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
   end

   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (rsp_stalls && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_tready = 1'b1;
      end
   end

   task automatic send(opcode_type op, logic [VADDR_W-1:0] va, logic [LEN_W-1:0] len,
                       logic [PERM_W-1:0] perm, logic [BTYPE_W-1:0] btype);
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 16) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {6'b0, btype, perm, len, va};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_command(op, va, len, perm, btype);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int pick_region();
      int live [$];
      for (int i = 0; i < SLOTS; i++)
         if (sb.slot_valid[i] && sb.slot_span[i] != 0) live.push_back(i);
      if (live.size() == 0) return -1;
      return live[$urandom_range(0, live.size() - 1)];
   endfunction

   task automatic random_command(bit fill_phase);
      int                 roll;
      int                 sel;
      int                 k;
      logic [63:0]        off;
      logic [63:0]        span;
      opcode_type         op;
      logic [VADDR_W-1:0] va;
      logic [LEN_W-1:0]   len;
      logic [PERM_W-1:0]  perm;
      logic [BTYPE_W-1:0] bt;
      roll = $urandom_range(0, 99);
      sel  = $urandom_range(0, 9);
      perm = 8'($urandom_range(0, 255));
      bt   = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) :
                                            3'($urandom_range(0, 5));
      va   = 47'($urandom_range(0, 'h7FFFF));
      len  = '0;
      k    = pick_region();
      if (roll < 5) begin
         op  = opcode_type'($urandom_range(0, 3));
         off = rand64();
         va  = off[VADDR_W-1:0];
         off = rand64();
         len = ($urandom_range(0, 49) == 0) ? 48'h8000_0000_0000 : {1'b0, off[46:0]};
         bt  = 3'($urandom_range(0, 7));
      end else if (roll < (fill_phase ? 50 : 20)) begin
         op = OP_MAP;
         if (sel < 3) begin
            len = 48'($urandom_range(0, 4095));
         end else if (sel < 9) begin
            len = 48'($urandom_range(1, 6)) * 48'd4096;
            if ($urandom_range(0, 1) == 0) len = len + 48'($urandom_range(1, 4095));
         end else begin
            off = SPACE_END - 64'($urandom_range(1, 4)) * PAGE +
                  64'($urandom_range(0, 4095));
            va  = off[VADDR_W-1:0];
            len = 48'($urandom_range(0, 5)) * 48'd4096;
         end
      end else if (roll < (fill_phase ? 65 : 25)) begin
         op  = OP_MMAP;
         bt  = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(0, 7)) :
               ($urandom_range(0, 1) == 0) ? BT_ANON : BT_SHARED;
         len = 48'($urandom_range(1, 4)) * 48'd4096;
         if (sel == 0) len = len + 48'($urandom_range(1, 4095));
         if ($urandom_range(0, 39) == 0) len = '0;
      end else if (roll < (fill_phase ? 85 : 55)) begin
         op = OP_LOOKUP;
         if (k >= 0 && sel < 8) begin
            span = 64'(sb.slot_span[k]);
            off  = 64'(sb.slot_start[k]) +
                   (($urandom_range(0, 4) == 0) ? span : rand64() % span);
            va   = off[VADDR_W-1:0];
         end
      end else begin
         op  = OP_UNMAP;
         len = 48'($urandom_range(0, 2)) * 48'd4096;
         if (k >= 0 && sel < 9) begin
            span = 64'(sb.slot_span[k]);
            va   = sb.slot_start[k];
            if (sel < 5) begin
               len = sb.slot_span[k];
            end else if (sel < 7) begin
               off = 64'(sb.slot_start[k]) + rand64() % span;
               va  = off[VADDR_W-1:0];
               len = '0;
            end else begin
               len = ($urandom_range(0, 1) == 0) ? sb.slot_span[k] + 48'd4096 :
                                                   sb.slot_span[k] - 48'd1;
            end
         end
      end
      send(op, va, len, perm, bt);
   endtask

   initial begin
      logic [63:0] tail_len;
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      req_gaps   = 1'b1;
      rsp_stalls = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table, field extremes, every type and every refusal but a full table
      send(OP_LOOKUP, 47'h0, 48'h0, 8'h00, BT_DATA);
      send(OP_UNMAP,  47'h0, 48'h0, 8'h00, BT_DATA);
      send(OP_MAP,    47'h1234, 48'h0, 8'h00, BT_DATA);
      send(OP_MAP,    47'h2000, 48'h2000, 8'h03, BT_NOCACHE);
      send(OP_MAP,    47'h3000, 48'h1001, 8'h00, BT_DEVICE);
      send(OP_MAP,    47'h4000, 48'h1, 8'hE7, BT_DEVICE);
      send(OP_MAP,    47'h9000, 48'h1000, 8'h01, 3'd6);
      send(OP_MAP,    47'h9000, 48'h1000, 8'h01, 3'd7);
      send(OP_MAP,    47'h7FFF_FFFF_F000, 48'h0, 8'hFF, BT_FORBIDDEN);
      send(OP_MAP,    47'h7FFF_FFFF_FFFF, 48'h1001, 8'h00, BT_ANON);
      send(OP_MAP,    47'h0, 48'h8000_0000_0000, 8'h55, BT_SHARED);
      send(OP_MMAP,   47'h0, 48'h1000, 8'h07, BT_ANON);
      send(OP_MMAP,   47'h0, 48'h0FFF, 8'h07, BT_SHARED);
      send(OP_MMAP,   47'h0, 48'h2000, 8'h07, BT_DATA);
      send(OP_MMAP,   47'h0, 48'h0, 8'h02, BT_SHARED);
      send(OP_MMAP,   47'h0, 48'h8000_0000_0000, 8'h02, BT_ANON);
      send(OP_MAP,    47'h7000_0000_3000, 48'h1000, 8'h00, BT_DATA);
      send(OP_MMAP,   47'h0, 48'h3000, 8'h06, BT_ANON);
      send(OP_MMAP,   47'h0, 48'h1000, 8'h06, BT_SHARED);
      send(OP_LOOKUP, 47'h7000_0000_0FFF, 48'h0, 8'h00, BT_DATA);
      send(OP_LOOKUP, 47'h7000_0000_1000, 48'h0, 8'h00, BT_DATA);
      send(OP_LOOKUP, 47'h2FFF, 48'h0, 8'h00, BT_DATA);
      send(OP_LOOKUP, 47'h7FFF_FFFF_FFFF, 48'h0, 8'h00, BT_DATA);
      send(OP_UNMAP,  47'h2000, 48'h1000, 8'h00, BT_DATA);
      send(OP_UNMAP,  47'h2000, 48'h2000, 8'h00, BT_DATA);
      send(OP_UNMAP,  47'h1800, 48'h0, 8'h00, BT_DATA);
      send(OP_UNMAP,  47'h7FFF_FFFF_F000, 48'h1000, 8'h00, BT_DATA);
      send(OP_LOOKUP, 47'h1800, 48'h0, 8'h00, BT_DATA);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         req_gaps   = (n < QUIET_FROM) && ((n / 40) % 3 != 2);
         rsp_stalls = (n < QUIET_FROM) && ((n / 40) % 3 != 1);
         random_command(((n / 50) % 2) == 0);
      end

      // drain the table, then run the bump cursor up to the end of the space
      for (int i = 0; i < SLOTS; i++)
         if (sb.slot_valid[i] && sb.slot_span[i] != 0)
            send(OP_UNMAP, sb.slot_start[i], sb.slot_span[i], 8'h00, BT_DATA);
      tail_len = SPACE_END - 64'(sb.bump_cursor);
      send(OP_MMAP,   47'h0, tail_len[LEN_W-1:0], 8'hFF, BT_ANON);
      send(OP_MMAP,   47'h0, 48'h0, 8'h01, BT_SHARED);
      send(OP_MMAP,   47'h0, 48'h1000, 8'h01, BT_SHARED);
      send(OP_LOOKUP, 47'h7FFF_FFFF_FFFF, 48'h0, 8'h00, BT_DATA);
      send(OP_UNMAP,  47'h7FFF_FFFF_FFFF, 48'h0, 8'h00, BT_DATA);

      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Ran %0d commands: %0d map, %0d mmap, %0d lookup, %0d unmap",
               sb.op_count[0] + sb.op_count[1] + sb.op_count[2] + sb.op_count[3],
               sb.op_count[0], sb.op_count[1], sb.op_count[2], sb.op_count[3]);
      $display("Outcomes: %0d ok, %0d overlap, %0d not found, %0d full, %0d bad request",
               sb.status_count[0], sb.status_count[1], sb.status_count[2],
               sb.status_count[3], sb.status_count[4]);
      if (sb.error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
